[hw/rtl/acde_pkg.sv]
// Shared types, codes and digit helpers for the alarm clock with digit edit.
// Used by acde_core and alarm_clock_with_digit_edit; no dependencies.
`timescale 1ns / 1ps

package acde_pkg;

   // Action codes of an input transaction.
   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_DIGIT       = 3'd1;
   localparam logic [2:0] ACT_INC         = 3'd2;
   localparam logic [2:0] ACT_DEC         = 3'd3;
   localparam logic [2:0] ACT_CURSOR_NEXT = 3'd4;
   localparam logic [2:0] ACT_CURSOR_PREV = 3'd5;
   localparam logic [2:0] ACT_TIME_KEY    = 3'd6;
   localparam logic [2:0] ACT_ALARM_KEY   = 3'd7;

   // Edit mode codes.
   localparam logic [1:0] MODE_RUN   = 2'd0;
   localparam logic [1:0] MODE_TIME  = 2'd1;
   localparam logic [1:0] MODE_ALARM = 2'd2;

   // Key press length codes; anything at or above PRESS_LONG counts as long.
   localparam logic [1:0] PRESS_SHORT = 2'd0;
   localparam logic [1:0] PRESS_LONG  = 2'd2;

   localparam int unsigned NUM_DIGITS = 6;
   localparam logic [2:0] CURSOR_LAST = 3'd5;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;
   localparam logic [3:0] TENS_MAX    = 4'd5;
   localparam logic [5:0] SIXTY_LAST  = 6'd59;
   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [6:0] HOURS_DAY   = 7'd24;
   localparam logic [7:0] TPS_RESET   = 8'd20;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] digit_value;
      logic [1:0] press_length;
   } item_type;

   typedef struct packed {
      logic [4:0] now_hours;
      logic [5:0] now_minutes;
      logic [5:0] now_seconds;
      logic       alarm_fired;
      logic       alarm_on;
      logic [1:0] mode;
      logic [2:0] cursor;
      logic [3:0] cursor_digit;
   } result_type;

   // Tens digit of a value below 60, found by a short compare chain.
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      t = 4'd0;
      for (int i = 1; i <= 5; i++) begin
         if (v >= 6'(i * 10)) t = 4'(i);
      end
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] v);
      logic [5:0] u;
      u = v - 6'(tens_of(v)) * 6'd10;
      return u[3:0];
   endfunction

   function automatic logic [6:0] to_value(input logic [3:0] t, input logic [3:0] u);
      return 7'(t) * 7'd10 + 7'(u);
   endfunction

endpackage

[hw/rtl/acde_core.sv]
// Clock, alarm and edit-digit state with the single-pass update for one transaction.
// Depends on acde_pkg for codes, types and digit helpers.
`timescale 1ns / 1ps

module acde_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  acde_pkg::item_type   item,
   input  logic [7:0]           ticks_per_second,
   output acde_pkg::result_type result
);

   logic [7:0] prescale_ff, prescale_in;
   logic [4:0] now_hour_ff, now_hour_in;
   logic [5:0] now_minute_ff, now_minute_in;
   logic [5:0] now_second_ff, now_second_in;
   logic [4:0] alarm_hour_ff, alarm_hour_in;
   logic [5:0] alarm_minute_ff, alarm_minute_in;
   logic [5:0] alarm_second_ff, alarm_second_in;
   logic       armed_ff, armed_in;
   logic [1:0] mode_ff, mode_in;
   logic [2:0] cursor_ff, cursor_in;
   logic [3:0] digits_ff [acde_pkg::NUM_DIGITS];
   logic [3:0] digits_in [acde_pkg::NUM_DIGITS];

   logic [3:0] cmt_digits [acde_pkg::NUM_DIGITS];
   logic [3:0] load_digits [acde_pkg::NUM_DIGITS];
   logic [6:0] cmt_hour, cmt_minute, cmt_second;
   logic [3:0] cur_digit, new_digit;
   logic [7:0] pre_inc;
   logic       editing, long_press, fired;

   // Digits after commit clamping, and the current time split into digits.
   always_comb begin
      cmt_digits = digits_ff;
      if (acde_pkg::to_value(digits_ff[0], digits_ff[1]) >= acde_pkg::HOURS_DAY) begin
         cmt_digits[0] = 4'd0;
         cmt_digits[1] = 4'd0;
      end
      if (digits_ff[2] > acde_pkg::TENS_MAX) cmt_digits[2] = acde_pkg::TENS_MAX;
      if (digits_ff[4] > acde_pkg::TENS_MAX) cmt_digits[4] = acde_pkg::TENS_MAX;
      cmt_hour   = acde_pkg::to_value(cmt_digits[0], cmt_digits[1]);
      cmt_minute = acde_pkg::to_value(cmt_digits[2], cmt_digits[3]);
      cmt_second = acde_pkg::to_value(cmt_digits[4], cmt_digits[5]);

      load_digits[0] = acde_pkg::tens_of({1'b0, now_hour_ff});
      load_digits[1] = acde_pkg::units_of({1'b0, now_hour_ff});
      load_digits[2] = acde_pkg::tens_of(now_minute_ff);
      load_digits[3] = acde_pkg::units_of(now_minute_ff);
      load_digits[4] = acde_pkg::tens_of(now_second_ff);
      load_digits[5] = acde_pkg::units_of(now_second_ff);
   end

   always_comb begin
      prescale_in     = prescale_ff;
      now_hour_in     = now_hour_ff;
      now_minute_in   = now_minute_ff;
      now_second_in   = now_second_ff;
      alarm_hour_in   = alarm_hour_ff;
      alarm_minute_in = alarm_minute_ff;
      alarm_second_in = alarm_second_ff;
      armed_in        = armed_ff;
      mode_in         = mode_ff;
      cursor_in       = cursor_ff;
      digits_in       = digits_ff;
      editing         = mode_ff != acde_pkg::MODE_RUN;
      long_press      = item.press_length >= acde_pkg::PRESS_LONG;
      pre_inc         = prescale_ff + 8'd1;
      fired           = 1'b0;

      cur_digit = 4'd0;
      for (int i = 0; i < acde_pkg::NUM_DIGITS; i++) begin
         if (cursor_ff == 3'(i)) cur_digit = digits_ff[i];
      end

      new_digit = cur_digit;
      case (item.action)
         acde_pkg::ACT_DIGIT: begin
            new_digit = (item.digit_value > acde_pkg::DIGIT_MAX) ? acde_pkg::DIGIT_MAX
                                                                 : item.digit_value;
         end
         acde_pkg::ACT_INC: begin
            if (cur_digit < acde_pkg::DIGIT_MAX) new_digit = cur_digit + 4'd1;
         end
         acde_pkg::ACT_DEC: begin
            if (cur_digit != 4'd0) new_digit = cur_digit - 4'd1;
         end
         default: new_digit = cur_digit;
      endcase

      case (item.action)
         acde_pkg::ACT_TICK: begin
            if (!editing) begin
               if (pre_inc < ticks_per_second) begin
                  prescale_in = pre_inc;
               end else begin
                  prescale_in = 8'd0;
                  if (now_second_ff < acde_pkg::SIXTY_LAST) begin
                     now_second_in = now_second_ff + 6'd1;
                  end else begin
                     now_second_in = 6'd0;
                     if (now_minute_ff < acde_pkg::SIXTY_LAST) begin
                        now_minute_in = now_minute_ff + 6'd1;
                     end else begin
                        now_minute_in = 6'd0;
                        now_hour_in = (now_hour_ff >= acde_pkg::HOUR_LAST) ? 5'd0
                                                                           : now_hour_ff + 5'd1;
                     end
                  end
               end
            end
         end
         acde_pkg::ACT_DIGIT, acde_pkg::ACT_INC, acde_pkg::ACT_DEC: begin
            if (editing) begin
               for (int i = 0; i < acde_pkg::NUM_DIGITS; i++) begin
                  if (cursor_ff == 3'(i)) digits_in[i] = new_digit;
               end
            end
         end
         acde_pkg::ACT_CURSOR_NEXT: begin
            if (editing) begin
               cursor_in = (cursor_ff >= acde_pkg::CURSOR_LAST) ? 3'd0 : cursor_ff + 3'd1;
            end
         end
         acde_pkg::ACT_CURSOR_PREV: begin
            if (editing) begin
               cursor_in = (cursor_ff == 3'd0) ? acde_pkg::CURSOR_LAST : cursor_ff - 3'd1;
            end
         end
         acde_pkg::ACT_TIME_KEY: begin
            if (mode_ff == acde_pkg::MODE_TIME) begin
               mode_in   = acde_pkg::MODE_RUN;
               cursor_in = acde_pkg::CURSOR_LAST;
               if (item.press_length == acde_pkg::PRESS_SHORT) begin
                  digits_in     = cmt_digits;
                  now_hour_in   = cmt_hour[4:0];
                  now_minute_in = cmt_minute[5:0];
                  now_second_in = cmt_second[5:0];
               end
            end else if (mode_ff == acde_pkg::MODE_RUN) begin
               digits_in = load_digits;
               mode_in   = acde_pkg::MODE_TIME;
            end
         end
         acde_pkg::ACT_ALARM_KEY: begin
            if (mode_ff != acde_pkg::MODE_TIME) begin
               if (long_press) begin
                  armed_in  = !armed_ff;
                  mode_in   = acde_pkg::MODE_RUN;
                  cursor_in = acde_pkg::CURSOR_LAST;
               end else if (mode_ff == acde_pkg::MODE_ALARM) begin
                  mode_in   = acde_pkg::MODE_RUN;
                  cursor_in = acde_pkg::CURSOR_LAST;
                  if (item.press_length == acde_pkg::PRESS_SHORT) begin
                     digits_in       = cmt_digits;
                     alarm_hour_in   = cmt_hour[4:0];
                     alarm_minute_in = cmt_minute[5:0];
                     alarm_second_in = cmt_second[5:0];
                  end
               end else begin
                  digits_in = load_digits;
                  mode_in   = acde_pkg::MODE_ALARM;
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      // The alarm fires once on a match and disarms itself.
      if (armed_in && now_hour_in == alarm_hour_in && now_minute_in == alarm_minute_in
          && now_second_in == alarm_second_in) begin
         fired    = 1'b1;
         armed_in = 1'b0;
      end

      result.now_hours    = now_hour_in;
      result.now_minutes  = now_minute_in;
      result.now_seconds  = now_second_in;
      result.alarm_fired  = fired;
      result.alarm_on     = armed_in;
      result.mode         = mode_in;
      result.cursor       = cursor_in;
      result.cursor_digit = 4'd0;
      for (int i = 0; i < acde_pkg::NUM_DIGITS; i++) begin
         if (cursor_in == 3'(i)) result.cursor_digit = digits_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff     <= 8'd0;
         now_hour_ff     <= 5'd0;
         now_minute_ff   <= 6'd0;
         now_second_ff   <= 6'd0;
         alarm_hour_ff   <= 5'd0;
         alarm_minute_ff <= 6'd0;
         alarm_second_ff <= 6'd0;
         armed_ff        <= 1'b0;
         mode_ff         <= acde_pkg::MODE_RUN;
         cursor_ff       <= acde_pkg::CURSOR_LAST;
         for (int i = 0; i < acde_pkg::NUM_DIGITS; i++) digits_ff[i] <= 4'd0;
      end else if (step_en) begin
         prescale_ff     <= prescale_in;
         now_hour_ff     <= now_hour_in;
         now_minute_ff   <= now_minute_in;
         now_second_ff   <= now_second_in;
         alarm_hour_ff   <= alarm_hour_in;
         alarm_minute_ff <= alarm_minute_in;
         alarm_second_ff <= alarm_second_in;
         armed_ff        <= armed_in;
         mode_ff         <= mode_in;
         cursor_ff       <= cursor_in;
         digits_ff       <= digits_in;
      end
   end

endmodule

[hw/rtl/alarm_clock_with_digit_edit.sv]
// Alarm clock with digit edit: top level with input register, result register
// and the ticks-per-second control register. Depends on acde_pkg and acde_core.
// A request is held in the input register and its core update is stored in the result register.
// Throughput: one transaction per cycle while rsp_ready stays high; the update is a single pass through acde_core.
// Reset (synchronous, active high) clears the clock and alarm, runs the clock,
// puts the cursor on the last digit and sets ticks_per_second to 20.
`timescale 1ns / 1ps

module alarm_clock_with_digit_edit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [3:0] req_digit_value,
   input  logic [1:0] req_press_length,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_now_hours,
   output logic [5:0] rsp_now_minutes,
   output logic [5:0] rsp_now_seconds,
   output logic       rsp_alarm_fired,
   output logic       rsp_alarm_on,
   output logic [1:0] rsp_mode,
   output logic [2:0] rsp_cursor,
   output logic [3:0] rsp_cursor_digit
);

   logic [7:0]           ticks_per_second_ff;
   logic                 item_valid_ff;
   acde_pkg::item_type   item_ff;
   logic                 rsp_valid_ff;
   acde_pkg::result_type rsp_ff;
   acde_pkg::result_type core_result;
   logic                 step_en;

   // A transaction leaves the input register when the result register is free or draining.
   assign step_en   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= acde_pkg::TPS_RESET;
      end else if (csr_wr_en) begin
         ticks_per_second_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.action       <= req_action;
         item_ff.digit_value  <= req_digit_value;
         item_ff.press_length <= req_press_length;
      end
   end

   acde_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .item             (item_ff),
      .ticks_per_second (ticks_per_second_ff),
      .result           (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) rsp_ff <= core_result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_now_hours    = rsp_ff.now_hours;
   assign rsp_now_minutes  = rsp_ff.now_minutes;
   assign rsp_now_seconds  = rsp_ff.now_seconds;
   assign rsp_alarm_fired  = rsp_ff.alarm_fired;
   assign rsp_alarm_on     = rsp_ff.alarm_on;
   assign rsp_mode         = rsp_ff.mode;
   assign rsp_cursor       = rsp_ff.cursor;
   assign rsp_cursor_digit = rsp_ff.cursor_digit;

endmodule
